/* hdl/trcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Report capture FIFO package
// Shared sizes, operation codes and the request and status structs that pass between
// the control unit and the top level.
// ----------------------------------------------------------------------------
package trcf_pkg;

  // Queue geometry.
  localparam int DEPTH        = 64;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int COUNT_W      = $clog2(DEPTH + 1);
  localparam int REPORT_BYTES = 8;
  localparam int STAMP_W      = 64;
  localparam int REPORT_W     = 64;
  localparam int ENTRY_W      = STAMP_W + REPORT_W;
  localparam int TOTAL_W      = 32;

  // Only the bytes of a real report are kept.
  localparam logic [REPORT_W-1:0] REPORT_MASK =
    {REPORT_W{1'b1}} >> (REPORT_W - 8 * REPORT_BYTES);
  localparam logic [7:0] GOOD_LENGTH = 8'(REPORT_BYTES);

  // Operation codes carried by an item.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Memory access requested for the item being accepted.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // Status of an item after its operation has been applied.
  typedef struct packed {
    logic               success;
    logic               pop_ok;
    logic [COUNT_W-1:0] fill;
    logic [TOTAL_W-1:0] invalid_total;
    logic [TOTAL_W-1:0] dropped_total;
    logic [TOTAL_W-1:0] accepted_total;
  } status_t;

endpackage
`default_nettype wire

/* hdl/trcf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module trcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/trcf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Report capture FIFO control
// Keeps the ring pointers, the fill count and the three event counters,
// and works out the memory access and status for each item.
// ----------------------------------------------------------------------------
module trcf_ctrl
  import trcf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] report_length,
  output mem_req_t        mem_req,
  output status_t         status
);

  logic [ADDR_W-1:0]  head;
  logic [ADDR_W-1:0]  tail;
  logic [COUNT_W-1:0] count;
  logic [TOTAL_W-1:0] invalid_cnt;
  logic [TOTAL_W-1:0] dropped_cnt;
  logic [TOTAL_W-1:0] accepted_cnt;

  logic [ADDR_W-1:0]  head_next;
  logic [ADDR_W-1:0]  tail_next;
  logic [COUNT_W-1:0] count_next;
  logic [TOTAL_W-1:0] invalid_cnt_next;
  logic [TOTAL_W-1:0] dropped_cnt_next;
  logic [TOTAL_W-1:0] accepted_cnt_next;
  logic               success;
  logic               pop_ok;
  logic               push_ok;

  // Apply one operation to the queue state.
  always_comb begin
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    invalid_cnt_next  = invalid_cnt;
    dropped_cnt_next  = dropped_cnt;
    accepted_cnt_next = accepted_cnt;
    success           = 1'b0;
    pop_ok            = 1'b0;
    push_ok           = 1'b0;
    unique case (operation)
      OP_PUSH: begin
        if (report_length != GOOD_LENGTH) begin
          invalid_cnt_next = invalid_cnt + TOTAL_W'(1);
        end else if (count == COUNT_W'(DEPTH)) begin
          dropped_cnt_next = dropped_cnt + TOTAL_W'(1);
        end else begin
          push_ok           = 1'b1;
          tail_next         = (tail == ADDR_W'(DEPTH - 1)) ? '0 : tail + ADDR_W'(1);
          count_next        = count + COUNT_W'(1);
          accepted_cnt_next = accepted_cnt + TOTAL_W'(1);
          success           = 1'b1;
        end
      end
      OP_POP: begin
        if (count != '0) begin
          pop_ok     = 1'b1;
          head_next  = (head == ADDR_W'(DEPTH - 1)) ? '0 : head + ADDR_W'(1);
          count_next = count - COUNT_W'(1);
          success    = 1'b1;
        end
      end
      OP_CLEAR: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
        success    = 1'b1;
      end
      default: begin
        // The unused code leaves the state alone and reports failure.
      end
    endcase
  end

  // Memory access and status for the item.
  always_comb begin
    mem_req.wr_en         = accept && push_ok;
    mem_req.wr_addr       = tail;
    mem_req.rd_en         = accept && pop_ok;
    mem_req.rd_addr       = head;
    status.success        = success;
    status.pop_ok         = pop_ok;
    status.fill           = count_next;
    status.invalid_total  = invalid_cnt_next;
    status.dropped_total  = dropped_cnt_next;
    status.accepted_total = accepted_cnt_next;
  end

  // State registers update only when an item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      invalid_cnt  <= '0;
      dropped_cnt  <= '0;
      accepted_cnt <= '0;
    end else if (accept) begin
      head         <= head_next;
      tail         <= tail_next;
      count        <= count_next;
      invalid_cnt  <= invalid_cnt_next;
      dropped_cnt  <= dropped_cnt_next;
      accepted_cnt <= accepted_cnt_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/timestamped_report_capture_fifo_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timestamped report capture FIFO
// A 64-entry ring of timestamped 8-byte keyboard reports with push, pop and
// clear operations and counters for invalid, dropped and accepted pushes.
// ----------------------------------------------------------------------------
// The block takes one item (push, pop or clear) in every clock cycle while
// in_stall is low and returns exactly one result per item, in order. At the
// accepting edge the queue state is updated, the status is captured and the
// entry RAM's registered read port fetches the popped entry; when the output
// register is free, both meet in it. Stalling the output backs up through
// these two registers to in_stall. After reset the queue is empty and all
// counters are zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module timestamped_report_capture_fifo_unit
  import trcf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          operation,
  input  wire logic [STAMP_W-1:0]  capture_time,
  input  wire logic [REPORT_W-1:0] report_bytes,
  input  wire logic [7:0]          report_length,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     success,
  output logic [STAMP_W-1:0]       event_timestamp,
  output logic [REPORT_W-1:0]      event_report,
  output logic [COUNT_W-1:0]       fill_level,
  output logic [TOTAL_W-1:0]       invalid_total,
  output logic [TOTAL_W-1:0]       dropped_total,
  output logic [TOTAL_W-1:0]       accepted_total
);

  logic               accept;
  logic               out_load;
  mem_req_t           mem_req;
  status_t            status;
  logic [ENTRY_W-1:0] rd_data;
  logic               s1_valid;
  status_t            s1_status;

  // Handshake: stage one moves on when the output register is free.
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign accept   = in_valid && !in_stall;

  // Queue control.
  trcf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .operation     (operation),
    .report_length (report_length),
    .mem_req       (mem_req),
    .status        (status)
  );

  // Entry storage: timestamp in the upper half, report in the lower half.
  trcf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data ({capture_time, report_bytes & REPORT_MASK}),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // Stage one valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage one status, aligned with the RAM read data.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register; entry fields are zero unless a pop returned an entry.
  always_ff @(posedge clk) begin
    if (out_load) begin
      success         <= s1_status.success;
      event_timestamp <= s1_status.pop_ok ? rd_data[ENTRY_W-1:REPORT_W] : '0;
      event_report    <= s1_status.pop_ok ? rd_data[REPORT_W-1:0] : '0;
      fill_level      <= s1_status.fill;
      invalid_total   <= s1_status.invalid_total;
      dropped_total   <= s1_status.dropped_total;
      accepted_total  <= s1_status.accepted_total;
    end
  end

endmodule
`default_nettype wire
